// File: hdl/itoa_pkg.sv
// Types, constants and the digit-to-character function for the integer-to-ASCII formatter.
// No dependencies; every other file depends on this package.
package itoa_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 5;
    localparam int BIN_W   = 32;
    localparam int BCD_W   = 40;
    localparam int NIB_N   = VALUE_W / 4;

    localparam logic [CHAR_W-1:0] C_MINUS = 8'h2D;

    typedef enum logic [OP_W-1:0] {
        FMT_SDEC32  = 3'd0,
        FMT_UDEC32  = 3'd1,
        FMT_HEX32_L = 3'd2,
        FMT_HEX32_U = 3'd3,
        FMT_HEX64_L = 3'd4
    } t_fmt_op;

    typedef enum logic [0:0] {
        TOP_IDLE,
        TOP_CONV
    } t_top_state;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SIGN,
        EMIT_CHAR
    } t_emit_state;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] digits;
        logic               neg;
        logic               upper;
    } t_emit_load;

    localparam logic [CHAR_W-1:0] HEX_LOWER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [CHAR_W-1:0] HEX_UPPER [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
        return upper ? HEX_UPPER[nib] : HEX_LOWER[nib];
    endfunction

endpackage

// File: hdl/itoa_if.sv
// Valid/ready channel interfaces for the formatter's input and character output.
// Depends on itoa_pkg for field widths.
interface itoa_in_if;
    logic                            valid;
    logic                            ready;
    logic [itoa_pkg::OP_W-1:0]       format_op;
    logic [itoa_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output format_op, output value, input ready);
    modport sink   (input valid, input format_op, input value, output ready);
endinterface

interface itoa_out_if;
    logic                            valid;
    logic                            ready;
    logic [itoa_pkg::CHAR_W-1:0]     char_code;
    logic                            last_char;
    logic [itoa_pkg::COUNT_W-1:0]    char_count;

    modport source (output valid, output char_code, output last_char, output char_count,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input char_count,
                    output ready);
endinterface

// File: hdl/integer_to_ascii_formatter_top.sv
// Hex modes: after accept, the leading zero nibbles of the 64-bit frame are skipped, then characters
// go out one per cycle while the output is not stalled.
// Decimal modes first run the bit-serial BCD conversion (one shift per input bit, then a done
// flag); a negative signed value gets a leading minus sign. One number in flight; the next is
// accepted while the last character waits in the output register. Synchronous active-low
// reset clears control. Top level; depends on itoa_pkg, itoa_if, itoa_dabble, itoa_emit.
module integer_to_ascii_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);
    import itoa_pkg::*;

    t_top_state          r_state, n_state;
    logic                r_neg;
    logic                r_upper;

    logic                accept;
    logic                is_dec;
    logic                is_hex;
    logic                emit_idle;
    logic                dab_start;
    logic                dab_done;
    logic [BCD_W-1:0]    dab_bcd;
    logic [BIN_W-1:0]    low_word;
    logic [BIN_W-1:0]    mag;
    t_emit_load          load;

    assign low_word = i_in.value[BIN_W-1:0];
    assign mag      = (t_fmt_op'(i_in.format_op) == FMT_SDEC32 && low_word[BIN_W-1])
                      ? (BIN_W'(0) - low_word) : low_word;

    always_comb begin
        is_dec = 1'b0;
        is_hex = 1'b0;
        unique case (i_in.format_op)
            FMT_SDEC32, FMT_UDEC32:                is_dec = 1'b1;
            FMT_HEX32_L, FMT_HEX32_U, FMT_HEX64_L: is_hex = 1'b1;
            default: ;
        endcase
    end

    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TOP_IDLE: begin
                if (accept && is_dec) n_state = TOP_CONV;
            end
            TOP_CONV: begin
                if (dab_done) n_state = TOP_IDLE;
            end
            default: n_state = TOP_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        dab_start   = 1'b0;
        load.valid  = 1'b0;
        load.digits = '0;
        load.neg    = 1'b0;
        load.upper  = 1'b0;
        unique case (r_state)
            TOP_IDLE: begin
                i_in.ready = emit_idle;
                dab_start  = accept && is_dec;
                load.valid = accept && is_hex;
                if (t_fmt_op'(i_in.format_op) == FMT_HEX64_L) begin
                    load.digits = i_in.value;
                end else begin
                    load.digits = {{(VALUE_W-BIN_W){1'b0}}, low_word};
                end
                load.upper = (t_fmt_op'(i_in.format_op) == FMT_HEX32_U);
            end
            TOP_CONV: begin
                load.valid  = dab_done;
                load.digits = {{(VALUE_W-BCD_W){1'b0}}, dab_bcd};
                load.neg    = r_neg;
                load.upper  = r_upper;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TOP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dab_start) begin
            r_neg   <= (t_fmt_op'(i_in.format_op) == FMT_SDEC32) && low_word[BIN_W-1];
            r_upper <= 1'b0;
        end
    end

    itoa_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_bin   (mag),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    itoa_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .o_idle  (emit_idle),
        .o_out   (o_out)
    );

endmodule

// File: hdl/itoa_dabble.sv
// Bit-serial binary-to-BCD converter (shift and add-3), one input bit per cycle.
// Depends on itoa_pkg.
module itoa_dabble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [itoa_pkg::BIN_W-1:0]    i_bin,
    output logic                          o_done,
    output logic [itoa_pkg::BCD_W-1:0]    o_bcd
);
    import itoa_pkg::*;

    localparam int CNT_W = $clog2(BIN_W + 1);
    localparam int DIG_N = BCD_W / 4;

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [BIN_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int d = 0; d < DIG_N; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(BIN_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_cnt != '0) begin
            r_bin <= {r_bin[BIN_W-2:0], 1'b0};
            r_bcd <= {adj[BCD_W-2:0], r_bin[BIN_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// File: hdl/itoa_emit.sv
// Nibble shifter that drops leading zeros and sends one character per cycle, while the output
// is not stalled, through an output register. Depends on itoa_pkg and itoa_if.
module itoa_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  itoa_pkg::t_emit_load  i_load,
    output logic                  o_idle,
    itoa_out_if.source            o_out
);
    import itoa_pkg::*;

    t_emit_state          r_state, n_state;
    logic [VALUE_W-1:0]   r_digits;
    logic [COUNT_W-1:0]   r_left;
    logic [COUNT_W-1:0]   r_cnt;
    logic                 r_neg;
    logic                 r_upper;

    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;
    logic [COUNT_W-1:0]   r_out_count;

    logic                 out_free;
    logic                 top_zero;
    logic                 last;
    logic                 do_skip;
    logic                 do_sign;
    logic                 do_char;

    assign out_free = !r_out_valid || o_out.ready;
    assign top_zero = (r_digits[VALUE_W-1 -: 4] == 4'd0);
    assign last     = (r_left == COUNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EMIT_IDLE: begin
                if (i_load.valid) n_state = EMIT_SKIP;
            end
            EMIT_SKIP: begin
                if (!(top_zero && !last)) n_state = r_neg ? EMIT_SIGN : EMIT_CHAR;
            end
            EMIT_SIGN: begin
                if (out_free) n_state = EMIT_CHAR;
            end
            EMIT_CHAR: begin
                if (out_free && last) n_state = EMIT_IDLE;
            end
            default: n_state = EMIT_IDLE;
        endcase
    end

    always_comb begin
        do_skip = 1'b0;
        do_sign = 1'b0;
        do_char = 1'b0;
        o_idle  = 1'b0;
        unique case (r_state)
            EMIT_IDLE: o_idle  = 1'b1;
            EMIT_SKIP: do_skip = top_zero && !last;
            EMIT_SIGN: do_sign = out_free;
            EMIT_CHAR: do_char = out_free;
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EMIT_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_sign || do_char) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid && r_state == EMIT_IDLE) begin
            r_digits <= i_load.digits;
            r_left   <= COUNT_W'(NIB_N);
            r_cnt    <= '0;
            r_neg    <= i_load.neg;
            r_upper  <= i_load.upper;
        end else if (do_skip || do_char) begin
            r_digits <= {r_digits[VALUE_W-5:0], 4'd0};
            r_left   <= r_left - COUNT_W'(1);
        end
        if (do_sign) begin
            r_out_char  <= C_MINUS;
            r_out_last  <= 1'b0;
            r_out_count <= '0;
            r_cnt       <= COUNT_W'(1);
        end else if (do_char) begin
            r_out_char  <= digit_char(r_digits[VALUE_W-1 -: 4], r_upper);
            r_out_last  <= last;
            r_out_count <= last ? (r_cnt + COUNT_W'(1)) : '0;
            r_cnt       <= r_cnt + COUNT_W'(1);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_code  = r_out_char;
    assign o_out.last_char  = r_out_last;
    assign o_out.char_count = r_out_count;

endmodule
